// ===== design/lpmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmsf_pkg
// Shared types and constants for the lazy Prim spanning forest engine.
// ----------------------------------------------------------------------------
package lpmsf_pkg;

    localparam int VERTEX_W      = 5;
    localparam int WEIGHT_W      = 16;
    localparam int TOTAL_W       = 21;
    localparam int VCOUNT_W      = 6;
    localparam int VCOUNT_RESET  = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_ROOT    = 16'h0002,
        S_SC_RD   = 16'h0004,
        S_SC_CHK  = 16'h0008,
        S_PU_RD   = 16'h0010,
        S_PU_CMP  = 16'h0020,
        S_POP     = 16'h0040,
        S_PO_TOP  = 16'h0080,
        S_PO_LAST = 16'h0100,
        S_SD_L    = 16'h0200,
        S_SD_R    = 16'h0400,
        S_SD_CMP  = 16'h0800,
        S_ACC     = 16'h1000,
        S_SCAN_A  = 16'h2000,
        S_SCAN_B  = 16'h4000,
        S_SUM     = 16'h8000
    } t_state;

    typedef struct packed {
        logic load;
        logic run_init;
        logic root_skip;
        logic scan_root;
        logic scan_next;
        logic push_start;
        logic wr_cur;
        logic move_up;
        logic rd_parent;
        logic rd_top;
        logic pop_take;
        logic pop_last;
        logic rd_left;
        logic take_left;
        logic move_down;
        logic emit_edge;
        logic scan_a;
        logic scan_b;
        logic emit_sum;
    } t_cmd;

    typedef struct packed {
        logic root_done;
        logic root_marked;
        logic scan_end;
        logic push_hit;
        logic hi_zero;
        logic cur_before;
        logic heap_empty;
        logic no_left;
        logic child_before;
        logic top_stale;
        logic a_marked;
        logic b_marked;
    } t_sts;

endpackage

// ===== design/lpmsf_ram.sv =====
// ----------------------------------------------------------------------------
// lpmsf_ram
// Simple dual-port RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module lpmsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
endmodule

// ===== design/lpmsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpmsf_ctrl
// Sequencer for loads, root selection, edge scans, heap push and pop.
// ----------------------------------------------------------------------------
module lpmsf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_operation,
    input  lpmsf_pkg::t_sts i_sts,
    output lpmsf_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import lpmsf_pkg::*;

    t_state r_state, n_state;
    logic   r_after_a, n_after_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after_a <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_after_a <= n_after_a;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_after_a = r_after_a;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_RUN) begin
                        o_cmd.run_init = 1'b1;
                        n_state        = S_ROOT;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_ROOT: begin
                if (i_sts.root_done) begin
                    n_state = S_SUM;
                end else if (i_sts.root_marked) begin
                    o_cmd.root_skip = 1'b1;
                end else begin
                    o_cmd.scan_root = 1'b1;
                    n_after_a       = 1'b0;
                    n_state         = S_SC_RD;
                end
            end
            S_SC_RD: begin
                if (i_sts.scan_end) begin
                    n_state = r_after_a ? S_SCAN_B : S_POP;
                end else begin
                    n_state = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                o_cmd.scan_next = 1'b1;
                if (i_sts.push_hit) begin
                    o_cmd.push_start = 1'b1;
                    n_state          = S_PU_RD;
                end else begin
                    n_state = S_SC_RD;
                end
            end
            S_PU_RD: begin
                if (i_sts.hi_zero) begin
                    o_cmd.wr_cur = 1'b1;
                    n_state      = S_SC_RD;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_PU_CMP;
                end
            end
            S_PU_CMP: begin
                if (i_sts.cur_before) begin
                    o_cmd.move_up = 1'b1;
                    n_state       = S_PU_RD;
                end else begin
                    o_cmd.wr_cur = 1'b1;
                    n_state      = S_SC_RD;
                end
            end
            S_POP: begin
                if (i_sts.heap_empty) begin
                    n_state = S_ROOT;
                end else begin
                    o_cmd.rd_top = 1'b1;
                    n_state      = S_PO_TOP;
                end
            end
            S_PO_TOP: begin
                o_cmd.pop_take = 1'b1;
                n_state        = S_PO_LAST;
            end
            S_PO_LAST: begin
                o_cmd.pop_last = 1'b1;
                n_state        = S_SD_L;
            end
            S_SD_L: begin
                if (i_sts.no_left) begin
                    o_cmd.wr_cur = 1'b1;
                    n_state      = S_ACC;
                end else begin
                    o_cmd.rd_left = 1'b1;
                    n_state       = S_SD_R;
                end
            end
            S_SD_R: begin
                o_cmd.take_left = 1'b1;
                n_state         = S_SD_CMP;
            end
            S_SD_CMP: begin
                if (i_sts.child_before) begin
                    o_cmd.move_down = 1'b1;
                    n_state         = S_SD_L;
                end else begin
                    o_cmd.wr_cur = 1'b1;
                    n_state      = S_ACC;
                end
            end
            S_ACC: begin
                if (i_sts.top_stale) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.emit_edge = 1'b1;
                    n_state         = S_SCAN_A;
                end
            end
            S_SCAN_A: begin
                if (!i_sts.a_marked) begin
                    o_cmd.scan_a = 1'b1;
                    n_after_a    = 1'b1;
                    n_state      = S_SC_RD;
                end else begin
                    n_state = S_SCAN_B;
                end
            end
            S_SCAN_B: begin
                if (!i_sts.b_marked) begin
                    o_cmd.scan_b = 1'b1;
                    n_after_a    = 1'b0;
                    n_state      = S_SC_RD;
                end else begin
                    n_state = S_POP;
                end
            end
            S_SUM: begin
                o_cmd.emit_sum = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ===== design/lpmsf_dp.sv =====
// ----------------------------------------------------------------------------
// lpmsf_dp
// Datapath: edge store, candidate heap, vertex marks, totals and outputs.
// ----------------------------------------------------------------------------
module lpmsf_dp #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lpmsf_pkg::t_cmd                     i_cmd,
    output lpmsf_pkg::t_sts                     o_sts,
    input  logic [lpmsf_pkg::VERTEX_W-1:0]      i_first_vertex,
    input  logic [lpmsf_pkg::VERTEX_W-1:0]      i_second_vertex,
    input  logic signed [lpmsf_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                                i_cfg_valid,
    input  logic [lpmsf_pkg::VCOUNT_W-1:0]      i_cfg_data,
    output logic                                o_strobe,
    output logic                                o_edge_valid,
    output logic [lpmsf_pkg::VERTEX_W-1:0]      o_tree_first,
    output logic [lpmsf_pkg::VERTEX_W-1:0]      o_tree_second,
    output logic signed [lpmsf_pkg::WEIGHT_W-1:0] o_tree_weight,
    output logic signed [lpmsf_pkg::TOTAL_W-1:0]  o_total_weight,
    output logic                                o_overflow,
    output logic                                o_is_last
);
    import lpmsf_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int SW  = (NW > VCOUNT_W) ? NW : VCOUNT_W;
    localparam int IW  = $clog2(MAX_EDGES);
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int XW  = IW + 2;
    localparam int ENW = 2 * VERTEX_W;
    localparam int EW  = WEIGHT_W + ENW;
    localparam int HW  = WEIGHT_W + IW + ENW;
    localparam int KW  = WEIGHT_W + IW;

    // Heap entry: {weight, edge index, second, first}. The order key flips the
    // weight sign bit so that one unsigned compare sorts by weight, then index.
    function automatic logic less(input logic [HW-1:0] x, input logic [HW-1:0] y);
        logic [KW-1:0] kx;
        logic [KW-1:0] ky;
        kx = {~x[HW-1], x[HW-2:ENW]};
        ky = {~y[HW-1], y[HW-2:ENW]};
        return kx < ky;
    endfunction

    logic [VCOUNT_W-1:0]     r_vc;
    logic [CW-1:0]           r_count;
    logic                    r_dropped;
    logic [MAX_VERTICES-1:0] r_marks;
    logic [NW-1:0]           r_root;
    logic [VW-1:0]           r_scan_v;
    logic [CW-1:0]           r_eidx;
    logic [CW-1:0]           r_hsize;
    logic [IW-1:0]           r_hi;
    logic [HW-1:0]           r_cur;
    logic [HW-1:0]           r_top;
    logic [HW-1:0]           r_left;
    logic                    r_has_right;
    logic signed [TOTAL_W-1:0] r_total;

    logic                    r_strobe;
    logic                    r_edge_valid;
    logic [VERTEX_W-1:0]     r_tree_first;
    logic [VERTEX_W-1:0]     r_tree_second;
    logic [WEIGHT_W-1:0]     r_tree_weight;
    logic [TOTAL_W-1:0]      r_total_out;
    logic                    r_overflow;
    logic                    r_is_last;

    logic [SW-1:0]           w_nv;
    logic                    w_load_ok;
    logic [EW-1:0]           w_e_rd;
    logic [HW-1:0]           w_h_rd;
    logic [VERTEX_W-1:0]     w_ea;
    logic [VERTEX_W-1:0]     w_eb;
    logic                    w_a_hit;
    logic                    w_b_hit;
    logic [VERTEX_W-1:0]     w_other;
    logic [IW-1:0]           w_parent;
    logic [XW-1:0]           w_left_x;
    logic [XW-1:0]           w_right_x;
    logic                    w_right_first;
    logic [HW-1:0]           w_best;
    logic [IW-1:0]           w_best_idx;
    logic [IW-1:0]           w_h_rd_addr;
    logic                    w_h_we;
    logic [HW-1:0]           w_h_wd;
    logic [VERTEX_W-1:0]     w_ta;
    logic [VERTEX_W-1:0]     w_tb;
    logic [TOTAL_W:0]        w_sum;
    logic [TOTAL_W-1:0]      w_sat;

    assign w_nv = (SW'(r_vc) < SW'(MAX_VERTICES)) ? SW'(r_vc) : SW'(MAX_VERTICES);
    assign w_load_ok = (r_count != CW'(MAX_EDGES)) && (SW'(i_first_vertex) < w_nv)
                       && (SW'(i_second_vertex) < w_nv);

    lpmsf_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.load && w_load_ok),
        .i_wr_addr(r_count[IW-1:0]),
        .i_wr_data({i_weight, i_second_vertex, i_first_vertex}),
        .i_rd_addr(r_eidx[IW-1:0]),
        .o_rd_data(w_e_rd)
    );

    lpmsf_ram #(.WIDTH(HW), .DEPTH(MAX_EDGES)) u_heap (
        .i_clk    (i_clk),
        .i_wr_en  (w_h_we),
        .i_wr_addr(r_hi),
        .i_wr_data(w_h_wd),
        .i_rd_addr(w_h_rd_addr),
        .o_rd_data(w_h_rd)
    );

    // Edge under scan: which end touches the scanned vertex.
    assign w_ea    = w_e_rd[VERTEX_W-1:0];
    assign w_eb    = w_e_rd[ENW-1:VERTEX_W];
    assign w_a_hit = (SW'(w_ea) == SW'(r_scan_v));
    assign w_b_hit = (SW'(w_eb) == SW'(r_scan_v));
    assign w_other = w_a_hit ? w_eb : w_ea;

    assign w_parent  = IW'((r_hi - IW'(1)) >> 1);
    assign w_left_x  = {1'b0, r_hi, 1'b1};
    assign w_right_x = {1'b0, r_hi, 1'b0} + XW'(2);

    assign w_right_first = r_has_right && less(w_h_rd, r_left);
    assign w_best        = w_right_first ? w_h_rd : r_left;
    assign w_best_idx    = w_right_first ? w_right_x[IW-1:0] : w_left_x[IW-1:0];

    always_comb begin
        priority if (i_cmd.rd_parent) begin
            w_h_rd_addr = w_parent;
        end else if (i_cmd.pop_take) begin
            w_h_rd_addr = IW'(r_hsize - CW'(1));
        end else if (i_cmd.rd_left) begin
            w_h_rd_addr = w_left_x[IW-1:0];
        end else if (i_cmd.take_left) begin
            w_h_rd_addr = w_right_x[IW-1:0];
        end else if (i_cmd.rd_top) begin
            w_h_rd_addr = '0;
        end else begin
            w_h_rd_addr = '0;
        end
    end

    assign w_h_we = i_cmd.wr_cur || i_cmd.move_up || i_cmd.move_down;
    always_comb begin
        priority if (i_cmd.move_up) begin
            w_h_wd = w_h_rd;
        end else if (i_cmd.move_down) begin
            w_h_wd = w_best;
        end else begin
            w_h_wd = r_cur;
        end
    end

    assign w_ta = r_top[VERTEX_W-1:0];
    assign w_tb = r_top[ENW-1:VERTEX_W];

    assign w_sum = {r_total[TOTAL_W-1], r_total}
                   + {{(TOTAL_W + 1 - WEIGHT_W){r_top[HW-1]}}, r_top[HW-1:HW-WEIGHT_W]};
    always_comb begin
        if (w_sum[TOTAL_W] != w_sum[TOTAL_W-1]) begin
            w_sat = w_sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                   : {1'b0, {(TOTAL_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[TOTAL_W-1:0];
        end
    end

    always_comb begin
        o_sts              = '0;
        o_sts.root_done    = (SW'(r_root) >= w_nv);
        o_sts.root_marked  = r_marks[r_root[VW-1:0]];
        o_sts.scan_end     = (r_eidx == r_count);
        o_sts.push_hit     = (w_a_hit || w_b_hit) && !r_marks[VW'(w_other)];
        o_sts.hi_zero      = (r_hi == '0);
        o_sts.cur_before   = less(r_cur, w_h_rd);
        o_sts.heap_empty   = (r_hsize == '0);
        o_sts.no_left      = (w_left_x >= XW'(r_hsize));
        o_sts.child_before = less(w_best, r_cur);
        o_sts.top_stale    = r_marks[VW'(w_ta)] && r_marks[VW'(w_tb)];
        o_sts.a_marked     = r_marks[VW'(w_ta)];
        o_sts.b_marked     = r_marks[VW'(w_tb)];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc      <= VCOUNT_W'(VCOUNT_RESET);
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_marks   <= '0;
            r_root    <= '0;
            r_eidx    <= '0;
            r_hsize   <= '0;
            r_total   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_edge || i_cmd.emit_sum;
            if (i_cfg_valid) begin
                r_vc <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (w_load_ok) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.run_init) begin
                r_marks <= '0;
                r_hsize <= '0;
                r_total <= '0;
                r_root  <= '0;
            end
            if (i_cmd.root_skip) begin
                r_root <= r_root + NW'(1);
            end
            if (i_cmd.scan_root) begin
                r_root                    <= r_root + NW'(1);
                r_marks[r_root[VW-1:0]]   <= 1'b1;
                r_eidx                    <= '0;
            end
            if (i_cmd.scan_a) begin
                r_marks[VW'(w_ta)] <= 1'b1;
                r_eidx             <= '0;
            end
            if (i_cmd.scan_b) begin
                r_marks[VW'(w_tb)] <= 1'b1;
                r_eidx             <= '0;
            end
            if (i_cmd.scan_next) begin
                r_eidx <= r_eidx + CW'(1);
            end
            if (i_cmd.push_start) begin
                r_hsize <= r_hsize + CW'(1);
            end
            if (i_cmd.pop_take) begin
                r_hsize <= r_hsize - CW'(1);
            end
            if (i_cmd.emit_edge) begin
                r_total <= w_sat;
            end
            if (i_cmd.emit_sum) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
                r_hsize   <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_root) begin
            r_scan_v <= r_root[VW-1:0];
        end
        if (i_cmd.scan_a) begin
            r_scan_v <= VW'(w_ta);
        end
        if (i_cmd.scan_b) begin
            r_scan_v <= VW'(w_tb);
        end
        if (i_cmd.push_start) begin
            r_cur <= {w_e_rd[EW-1:ENW], r_eidx[IW-1:0], w_e_rd[ENW-1:0]};
            r_hi  <= r_hsize[IW-1:0];
        end
        if (i_cmd.move_up) begin
            r_hi <= w_parent;
        end
        if (i_cmd.pop_take) begin
            r_top <= w_h_rd;
        end
        if (i_cmd.pop_last) begin
            r_cur <= w_h_rd;
            r_hi  <= '0;
        end
        if (i_cmd.take_left) begin
            r_left      <= w_h_rd;
            r_has_right <= (w_right_x < XW'(r_hsize));
        end
        if (i_cmd.move_down) begin
            r_hi <= w_best_idx;
        end
        if (i_cmd.emit_edge) begin
            r_edge_valid  <= 1'b1;
            r_tree_first  <= w_ta;
            r_tree_second <= w_tb;
            r_tree_weight <= r_top[HW-1:HW-WEIGHT_W];
            r_total_out   <= w_sat;
            r_overflow    <= r_dropped;
            r_is_last     <= 1'b0;
        end
        if (i_cmd.emit_sum) begin
            r_edge_valid  <= 1'b0;
            r_tree_first  <= '0;
            r_tree_second <= '0;
            r_tree_weight <= '0;
            r_total_out   <= r_total;
            r_overflow    <= r_dropped;
            r_is_last     <= 1'b1;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_edge_valid   = r_edge_valid;
    assign o_tree_first   = r_tree_first;
    assign o_tree_second  = r_tree_second;
    assign o_tree_weight  = r_tree_weight;
    assign o_total_weight = r_total_out;
    assign o_overflow     = r_overflow;
    assign o_is_last      = r_is_last;
endmodule

// ===== design/lazy_prim_min_spanning_forest.sv =====
// ----------------------------------------------------------------------------
// lazy_prim_min_spanning_forest
// Minimum spanning forest engine using lazy Prim over a loaded edge list.
// ----------------------------------------------------------------------------
// A load is done in the idle state and never raises busy, so loads may
// follow back to back. A run keeps busy high until its summary beat has been
// issued; its length depends on the graph: every scanned vertex walks the
// whole edge store, each push climbs the heap level by level, and each pop
// sifts the last entry down from the top level by level. Every heap step
// waits on the registered read of the heap RAM, which has one read port and
// one write port. Result beats come on o_strobe for one cycle each and
// cannot be stalled; the summary beat (o_is_last) is on the ports in the
// first cycle that busy is low.
module lazy_prim_min_spanning_forest #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_operation,
    input  logic [lpmsf_pkg::VERTEX_W-1:0]        i_first_vertex,
    input  logic [lpmsf_pkg::VERTEX_W-1:0]        i_second_vertex,
    input  logic signed [lpmsf_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lpmsf_pkg::VCOUNT_W-1:0]        i_cfg_data,
    output logic                                  o_strobe,
    output logic                                  o_edge_valid,
    output logic [lpmsf_pkg::VERTEX_W-1:0]        o_tree_first,
    output logic [lpmsf_pkg::VERTEX_W-1:0]        o_tree_second,
    output logic signed [lpmsf_pkg::WEIGHT_W-1:0] o_tree_weight,
    output logic signed [lpmsf_pkg::TOTAL_W-1:0]  o_total_weight,
    output logic                                  o_overflow,
    output logic                                  o_is_last
);
    import lpmsf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    lpmsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_operation(i_operation),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (busy)
    );

    lpmsf_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_first_vertex (i_first_vertex),
        .i_second_vertex(i_second_vertex),
        .i_weight       (i_weight),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_edge_valid   (o_edge_valid),
        .o_tree_first   (o_tree_first),
        .o_tree_second  (o_tree_second),
        .o_tree_weight  (o_tree_weight),
        .o_total_weight (o_total_weight),
        .o_overflow     (o_overflow),
        .o_is_last      (o_is_last)
    );

`ifndef SYNTHESIS
    // Result beats are never adjacent.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result beats");

    // The summary beat is never a tree edge.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_last) |-> !o_edge_valid)
        else $error("summary beat marked as tree edge");

    // A run leaves idle at once.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_RUN)) |=> busy)
        else $error("run not started");

    // The run is over once its summary beat is out.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_last) |-> !busy)
        else $error("busy after summary beat");
`endif
endmodule
